// ===== src/lifo_stack_allocator_top_macros.svh =====
// lifo_stack_allocator_top_macros.svh: assertion macros for the stack allocator
// used by lifo_stack_allocator_top.sv; needs a clk and rst in scope at the point of use
`ifndef LIFO_STACK_ALLOCATOR_TOP_MACROS_SVH
`define LIFO_STACK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define LSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define LSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lsa_pkg.sv =====
// lsa_pkg.sv: word types, status codes and register indexes of the stack allocator
// no dependencies; imported by lifo_stack_allocator_top, lsa_checker and tb_top
package lsa_pkg;

  // input word: one allocate or free request
  typedef struct packed {
    logic        func;
    logic [16:0] request_bytes;
    logic [3:0]  align_log2;
    logic [31:0] free_address;
  } in_word_t;

  // output word: one result per request
  typedef struct packed {
    logic [31:0] user_address;
    logic [2:0]  status;
    logic [16:0] bytes_in_use;
    logic [8:0]  live_count;
  } out_word_t;

  // request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd1;
  localparam logic [2:0] ST_NULL       = 3'd2;
  localparam logic [2:0] ST_NOT_NEWEST = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  // configuration register indexes
  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  // configuration reset values
  localparam logic [31:0] POOL_BASE_RESET = 32'd0;
  localparam logic [16:0] POOL_SIZE_RESET = 17'd65536;

endpackage

// ===== src/lsa_ram.sv =====
// lsa_ram.sv: generic single write port, single read port ram with registered read
// no dependencies; holds the allocation record stack
module lsa_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, returns old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/lifo_stack_allocator_top.sv =====
// lifo_stack_allocator_top.sv: lifo bump allocator over one pool with aligned addresses
// depends on lsa_pkg, lsa_ram and lifo_stack_allocator_top_macros.svh
//
// Usage:
//   Input channel in_valid/in_stall/in_word carries allocate or free requests; a word
//   is taken at a rising edge with in_valid high and in_stall low. Output channel
//   out_valid/out_stall/out_word gives one result word per request, in order.
//   cfg_we/cfg_index/cfg_data writes pool_base (index 0) or pool_size (index 1);
//   write only while no request is outstanding.
//   A request taken into the input register is decoded there, and its result word
//   is written to the result register, which drives out_word.
//   Throughput: one request per cycle unless the receiver stalls, set by the single
//   register-to-register pass that updates the top offset and allocation count; the
//   newest allocation record sits in the record ram's read register, read ahead each
//   cycle at the new stack top, with a bypass for a record written in the same cycle.
//   When the receiver stalls, the result register holds its word and one further
//   request is held in the input register; in_stall then rises until the result goes.
//   Reset (synchronous, active high) empties the pipeline, sets the top offset and
//   count to zero, pool_base to 0 and pool_size to 65536. The record ram is not
//   cleared: only records below the live count are ever read, and those were written.
`include "lifo_stack_allocator_top_macros.svh"

module lifo_stack_allocator_top #(
  parameter int HEADER_BYTES = 8,
  parameter int MAX_ALLOCS   = 256,
  parameter int POOL_BYTES   = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lsa_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output lsa_pkg::out_word_t out_word,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  import lsa_pkg::*;

  // widths
  localparam int OFFW = $clog2(POOL_BYTES + 1);
  localparam int REQW = 18;
  localparam int SUMW = ((OFFW > REQW) ? OFFW : REQW) + 1;
  localparam int CW   = $clog2(MAX_ALLOCS + 1);
  localparam int AW   = $clog2(MAX_ALLOCS);
  localparam int ENTW = 32 + OFFW;

  // configuration
  logic [31:0] pool_base;
  logic [16:0] pool_size;

  // pipeline registers
  logic      in_full;
  in_word_t  in_reg;
  out_word_t out_reg;

  // allocator state
  logic [OFFW-1:0] top_offset, top_offset_next;
  logic [CW-1:0]   alloc_count, alloc_count_next;

  // record stack
  logic            ram_we;
  logic [AW-1:0]   ram_wr_addr, ram_rd_addr;
  logic [ENTW-1:0] ram_wr_data, ram_rd_data;
  logic            bypass_hit;
  logic [ENTW-1:0] bypass_data;
  logic [ENTW-1:0] top_entry;
  logic [CW-1:0]   count_less;

  // datapath
  logic            advance;
  logic            do_push, do_pop;
  logic [REQW-1:0] actual;
  logic [SUMW-1:0] sum_top, limit;
  logic [31:0]     mask, raw, addr;
  out_word_t       result;

  // handshake
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= POOL_BASE_RESET;
      pool_size <= POOL_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_BASE: pool_base <= cfg_data;
        CFG_POOL_SIZE: pool_size <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_word;
    end
  end

  // newest record, with bypass of a record written at the last edge
  assign top_entry = bypass_hit ? bypass_data : ram_rd_data;

  // reservation size, alignment mask and limit
  always_comb begin
    actual  = REQW'(HEADER_BYTES) + REQW'(in_reg.request_bytes)
              + (REQW'(1) << in_reg.align_log2);
    sum_top = SUMW'(top_offset) + SUMW'(actual);
    limit   = (SUMW'(pool_size) < SUMW'(POOL_BYTES)) ? SUMW'(pool_size) : SUMW'(POOL_BYTES);
    mask    = (32'd1 << in_reg.align_log2) - 32'd1;
    raw     = pool_base + 32'(top_offset) + 32'(HEADER_BYTES);
    addr    = (raw + mask) & ~mask;
  end

  // request decode and next state
  always_comb begin
    do_push          = 1'b0;
    do_pop           = 1'b0;
    top_offset_next  = top_offset;
    alloc_count_next = alloc_count;
    result.user_address = 32'd0;
    result.status       = ST_OK;
    if (in_reg.func == FUNC_ALLOC) begin
      if (alloc_count == CW'(MAX_ALLOCS)) begin
        result.status = ST_FULL;
      end else if (sum_top > limit) begin
        result.status = ST_EXHAUSTED;
      end else begin
        do_push             = advance;
        result.user_address = addr;
      end
    end else begin
      if (in_reg.free_address == 32'd0) begin
        result.status = ST_NULL;
      end else if (alloc_count == '0 || top_entry[ENTW-1:OFFW] != in_reg.free_address) begin
        result.status = ST_NOT_NEWEST;
      end else begin
        do_pop = advance;
      end
    end
    if (do_push) begin
      top_offset_next  = sum_top[OFFW-1:0];
      alloc_count_next = alloc_count + 1'b1;
    end else if (do_pop) begin
      top_offset_next  = top_entry[OFFW-1:0];
      alloc_count_next = alloc_count - 1'b1;
    end
    result.bytes_in_use = 17'(top_offset_next);
    result.live_count   = 9'(alloc_count_next);
  end

  // record ram: push writes at the old count, read ahead at the new top
  assign ram_we      = do_push;
  assign ram_wr_addr = alloc_count[AW-1:0];
  assign ram_wr_data = {addr, top_offset};
  assign count_less  = alloc_count_next - 1'b1;
  assign ram_rd_addr = count_less[AW-1:0];

  lsa_ram #(
    .WIDTH (ENTW),
    .DEPTH (MAX_ALLOCS)
  ) u_records (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // bypass for a read of the address written at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_hit <= 1'b0;
    end else begin
      bypass_hit <= ram_we && (ram_wr_addr == ram_rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    bypass_data <= ram_wr_data;
  end

  // allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      top_offset  <= '0;
      alloc_count <= '0;
    end else begin
      top_offset  <= top_offset_next;
      alloc_count <= alloc_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign out_word = out_reg;

  // checks
  `LSA_ASSERT_NOW(a_count_range, 1'b1, alloc_count <= CW'(MAX_ALLOCS), "live count beyond record depth")
  `LSA_ASSERT_NEXT(a_push_count, do_push, alloc_count == CW'($past(alloc_count) + 1'b1), "push did not bump count")
  `LSA_ASSERT_NEXT(a_idle_state, !advance, $stable(top_offset) && $stable(alloc_count), "state moved without a request")

endmodule

// ===== bench/lsa_checker.sv =====
// lsa_checker.sv: watches both word channels and the register port of the stack allocator,
// forecasts each result word and compares it with what comes out
// depends on lsa_pkg; instantiated beside the block by tb_top
module lsa_checker #(
  parameter int HEADER_BYTES = 8,
  parameter int MAX_ALLOCS   = 256,
  parameter int POOL_BYTES   = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  lsa_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  lsa_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 pending,
  output int                 failures,
  output logic [31:0]        newest_addr,
  output logic [8:0]         live_after
);
  import lsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the allocator state and its registers
  logic [31:0] base_q = POOL_BASE_RESET;
  logic [16:0] size_q = POOL_SIZE_RESET;
  logic [16:0] top_q = '0;
  logic [8:0]  count_q = '0;
  logic [16:0] saved_top [MAX_ALLOCS];
  logic [31:0] addr_stack [MAX_ALLOCS];

  out_word_t   due_q [$];
  out_word_t   want_r, fresh_r, peek_r;
  logic [8:0]  peek_n;
  logic [31:0] peek_a;
  int          bad = 0;

  // result word that one request word yields from the current shadow state
  function automatic out_word_t forecast(input in_word_t w);
    out_word_t   r;
    logic [19:0] span;
    logic [16:0] cap;
    logic [31:0] mask;
    logic [31:0] raw;
    r = '0;
    r.status = ST_OK;
    r.bytes_in_use = top_q;
    r.live_count = count_q;
    if (w.func == FUNC_ALLOC) begin
      span = 20'(HEADER_BYTES) + 20'(w.request_bytes) + (20'd1 << w.align_log2);
      cap = (size_q < 17'(POOL_BYTES)) ? size_q : 17'(POOL_BYTES);
      // a full record stack wins over an exhausted pool
      if (int'(count_q) >= MAX_ALLOCS) begin
        r.status = ST_FULL;
      end else if (20'(top_q) + span > 20'(cap)) begin
        r.status = ST_EXHAUSTED;
      end else begin
        mask = (32'd1 << w.align_log2) - 32'd1;
        raw = base_q + 32'(top_q) + 32'(HEADER_BYTES);
        r.user_address = (raw + mask) & ~mask;
        r.bytes_in_use = top_q + 17'(span);
        r.live_count = count_q + 9'd1;
      end
    end else if (w.free_address == 32'd0) begin
      r.status = ST_NULL;
    end else if (count_q == 9'd0 || addr_stack[count_q - 9'd1] != w.free_address) begin
      r.status = ST_NOT_NEWEST;
    end else begin
      r.live_count = count_q - 9'd1;
      r.bytes_in_use = saved_top[count_q - 9'd1];
    end
    return r;
  endfunction

  // compare results, forecast accepted requests, follow register writes
  always @(posedge clk) begin
    if (rst) begin
      base_q = POOL_BASE_RESET;
      size_q = POOL_SIZE_RESET;
      top_q = '0;
      count_q = '0;
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("unexpected result word: addr %h st %0d used %0d live %0d",
                     out_word.user_address, out_word.status, out_word.bytes_in_use,
                     out_word.live_count);
        end else begin
          want_r = due_q.pop_front();
          if (out_word.user_address !== want_r.user_address ||
              out_word.status !== want_r.status ||
              out_word.bytes_in_use !== want_r.bytes_in_use ||
              out_word.live_count !== want_r.live_count) begin
            bad++;
            if (bad <= 10)
              $display({"mismatch: expected addr %h st %0d used %0d live %0d,",
                        " got addr %h st %0d used %0d live %0d"},
                       want_r.user_address, want_r.status, want_r.bytes_in_use,
                       want_r.live_count, out_word.user_address, out_word.status,
                       out_word.bytes_in_use, out_word.live_count);
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh_r = forecast(in_word);
        // a granted allocate records the old top and its address
        if (in_word.func == FUNC_ALLOC && fresh_r.status == ST_OK) begin
          saved_top[count_q] = top_q;
          addr_stack[count_q] = fresh_r.user_address;
        end
        top_q = fresh_r.bytes_in_use;
        count_q = fresh_r.live_count;
        due_q.push_back(fresh_r);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_POOL_BASE)
          base_q = cfg_data;
        else
          size_q = cfg_data[16:0];
      end
    end
    pending <= due_q.size();
    failures <= bad;
  end

  // newest live address and count once the word now offered is taken, for the stimulus
  always @(negedge clk) begin
    peek_n = count_q;
    peek_a = (count_q != 9'd0) ? addr_stack[count_q - 9'd1] : 32'd0;
    if (!rst && in_valid && !in_stall) begin
      peek_r = forecast(in_word);
      peek_n = peek_r.live_count;
      if (peek_n > count_q)
        peek_a = peek_r.user_address;
      else if (peek_n < count_q)
        peek_a = (peek_n != 9'd0) ? addr_stack[peek_n - 9'd1] : 32'd0;
    end
    newest_addr = peek_a;
    live_after = peek_n;
  end

endmodule

// ===== bench/tb_top.sv =====
// tb_top.sv: stimulus and verdict for the stack allocator; directed requests, a full
// record stack, then random phases under several pool settings
// depends on lsa_pkg, lifo_stack_allocator_top and lsa_checker
module tb_top;
  import lsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEADER_BYTES = 8;
  localparam int MAX_ALLOCS   = 256;
  localparam int POOL_BYTES   = 65536;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_POOL_BASE;
  logic [31:0] cfg_data = '0;

  int          pending;
  int          failures;
  logic [31:0] newest_addr;
  logic [8:0]  live_after;

  logic        quiet = 1'b0;
  int          n_sent = 0;
  int          n_writes = 0;
  int          peak_live = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lifo_stack_allocator_top #(
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_ALLOCS  (MAX_ALLOCS),
    .POOL_BYTES  (POOL_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  lsa_checker #(
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_ALLOCS  (MAX_ALLOCS),
    .POOL_BYTES  (POOL_BYTES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .failures   (failures),
    .newest_addr(newest_addr),
    .live_after (live_after)
  );

  // receiver stalls now and then
  always @(posedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(99) < 8);
  end

  // allocate word; the unused address field carries noise
  function automatic in_word_t alloc_word(input logic [16:0] req, input logic [3:0] lg);
    in_word_t w;
    w.func = FUNC_ALLOC;
    w.request_bytes = req;
    w.align_log2 = lg;
    w.free_address = $urandom;
    return w;
  endfunction

  // free word; size and alignment fields carry noise
  function automatic in_word_t free_word(input logic [31:0] addr);
    in_word_t w;
    w.func = FUNC_FREE;
    w.request_bytes = 17'($urandom);
    w.align_log2 = 4'($urandom);
    w.free_address = addr;
    return w;
  endfunction

  // mostly well-formed allocate and free pairs, some broken frees and raw noise
  function automatic in_word_t random_word();
    int       pick;
    in_word_t w;
    pick = $urandom_range(99);
    if (pick < 40) return alloc_word(17'($urandom_range(64)), 4'($urandom_range(6)));
    if (pick < 45) return alloc_word(17'($urandom_range(4096)), 4'($urandom_range(12)));
    if (pick < 50) return alloc_word(17'($urandom), 4'($urandom));
    if (pick < 80) return free_word(newest_addr);
    if (pick < 84) return free_word(newest_addr + 32'($urandom_range(64, 1)));
    if (pick < 86) return free_word($urandom);
    if (pick < 91) return free_word(32'd0);
    w.func = 1'($urandom);
    w.request_bytes = 17'($urandom);
    w.align_log2 = 4'($urandom);
    w.free_address = $urandom;
    return w;
  endfunction

  // pool size register data with junk above the 17 bits used
  function automatic logic [31:0] size_data(input logic [16:0] s);
    return {15'($urandom), s};
  endfunction

  // offer one word, hold it until taken, then maybe leave a gap
  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (int'(live_after) > peak_live) peak_live = int'(live_after);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: null and empty frees, pool boundaries, alignment extremes
    send_word(free_word(32'd0));
    send_word(free_word(32'h0000_1234));
    send_word(alloc_word(17'd0, 4'd0));
    send_word(alloc_word(17'd100, 4'd12));
    send_word(free_word(newest_addr ^ 32'd1));
    send_word(free_word(newest_addr));
    send_word(free_word(newest_addr));
    send_word(alloc_word(17'h10000, 4'd0));
    send_word(alloc_word(17'd65527, 4'd0));
    send_word(alloc_word(17'd0, 4'd0));
    send_word(free_word(newest_addr));
    send_word(alloc_word(17'd0, 4'd15));
    send_word(alloc_word(17'd0, 4'd15));
    send_word(alloc_word(17'h1FFFF, 4'hF));
    // free straight behind its own allocate
    send_word(alloc_word(17'd5, 4'd3));
    send_word(free_word(newest_addr));
    send_word(free_word(newest_addr));

    // pool base just below the top of the address space
    drain();
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFF9);
    send_word(alloc_word(17'd3, 4'd4));
    send_word(free_word(newest_addr));

    // empty pool, then a size above the hard limit with an unaligned base
    drain();
    write_reg(CFG_POOL_BASE, 32'h0000_1003);
    write_reg(CFG_POOL_SIZE, size_data(17'd0));
    send_word(alloc_word(17'd0, 4'd0));
    send_word(free_word(32'h0000_100B));
    drain();
    write_reg(CFG_POOL_SIZE, size_data(17'h1FFFF));
    send_word(alloc_word(17'd65527, 4'd0));
    send_word(free_word(newest_addr));

    // fill the record stack, knock on it, then unwind it
    drain();
    write_reg(CFG_POOL_BASE, 32'd0);
    write_reg(CFG_POOL_SIZE, size_data(17'h10000));
    for (int k = 0; k < 300 && live_after != 9'd0; k++)
      send_word(free_word(newest_addr));
    for (int k = 0; k < 300 && int'(live_after) < MAX_ALLOCS; k++)
      send_word(alloc_word(17'($urandom_range(15)), 4'($urandom_range(3))));
    send_word(alloc_word(17'd0, 4'd0));
    send_word(alloc_word(17'h1FFFF, 4'hF));
    send_word(free_word(newest_addr + 32'd1));
    for (int k = 0; k < 300 && live_after != 9'd0; k++)
      send_word(free_word(newest_addr));

    // random phases; live allocations carry over each register change
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(CFG_POOL_BASE, 32'hFFFF_FF00);
          write_reg(CFG_POOL_SIZE, size_data(17'h1FFFF));
        end
        1: begin
          write_reg(CFG_POOL_BASE, $urandom);
          write_reg(CFG_POOL_SIZE, size_data(17'd0));
        end
        2: begin
          write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
          write_reg(CFG_POOL_SIZE, size_data(17'd512));
        end
        3: begin
          write_reg(CFG_POOL_BASE, $urandom);
          write_reg(CFG_POOL_SIZE, $urandom);
        end
        4: begin
          write_reg(CFG_POOL_BASE, 32'h0000_1003);
          write_reg(CFG_POOL_SIZE, size_data(17'd65535));
        end
        default: begin
          write_reg(CFG_POOL_BASE, 32'd0);
          write_reg(CFG_POOL_SIZE, size_data(17'h10000));
        end
      endcase
      quiet <= (p == 2);
      repeat (70) send_word(random_word());
    end

    // wait out the last results and the pipeline
    drain();
    quiet <= 1'b0;
    repeat (8) @(posedge clk);
    $display("run covered %0d request words and %0d register writes, peak live count %0d",
             n_sent, n_writes, peak_live);
    $display("including a full record stack, wrapped and unaligned bases, empty and oversize pools");
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // hang guard
  initial begin
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/lsa_pkg.sv
src/lsa_ram.sv
src/lifo_stack_allocator_top.sv
bench/lsa_checker.sv
bench/tb_top.sv
